### hdl/run_length_byte_decoder_top_macros.svh
// assertion macros used by the decoder datapath
`ifndef RUN_LENGTH_BYTE_DECODER_TOP_MACROS_SVH
`define RUN_LENGTH_BYTE_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define RLBD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rlbd assertion failed");

// next-cycle implication
`define RLBD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rlbd assertion failed");

`endif

### hdl/rlbd_pkg.sv
package rlbd_pkg;

	localparam logic [5:0] THRESHOLD_RESET = 6'd63;
	localparam logic [7:0] REPEAT_MAX      = 8'd64;
	localparam logic       REG_THRESHOLD   = 1'b0;

	localparam logic       REQ_DATA  = 1'b0;
	localparam logic       REQ_CHECK = 1'b1;

	localparam logic [1:0] STAT_BYTE     = 2'd0;
	localparam logic [1:0] STAT_COMPLETE = 2'd1;
	localparam logic [1:0] STAT_REP_OPEN = 2'd2;
	localparam logic [1:0] STAT_LIT_OPEN = 2'd3;

	typedef enum logic [1:0] {
		MODE_DIR = 2'd0,
		MODE_REP = 2'd1,
		MODE_LIT = 2'd2
	} mode_t;

	typedef enum logic {
		ST_ACCEPT = 1'b0,
		ST_REPEAT = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic emit_rep;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic start_rep;
		logic rep_last;
	} dp_sts_t;

endpackage

### hdl/rlbd_regs.sv
module rlbd_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [5:0]  threshold
);

	logic [5:0] threshold_q;
	logic       wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == rlbd_pkg::REG_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= rlbd_pkg::THRESHOLD_RESET;
		end else if (wr_hit) begin
			threshold_q <= pwdata[5:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == rlbd_pkg::REG_THRESHOLD) begin
			prdata = {26'd0, threshold_q};
		end
	end

	assign threshold = threshold_q;

endmodule

### hdl/rlbd_ctl.sv
module rlbd_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rlbd_pkg::dp_sts_t   sts,
	output rlbd_pkg::ctl_cmd_t  cmd
);

	rlbd_pkg::ctl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlbd_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rlbd_pkg::ST_ACCEPT: begin
				if (in_valid && sts.slot_free && sts.start_rep) begin
					state_nxt = rlbd_pkg::ST_REPEAT;
				end
			end
			rlbd_pkg::ST_REPEAT: begin
				if (sts.slot_free && sts.rep_last) begin
					state_nxt = rlbd_pkg::ST_ACCEPT;
				end
			end
			default: state_nxt = rlbd_pkg::ST_ACCEPT;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.emit_rep = 1'b0;
		unique case (state_q)
			rlbd_pkg::ST_ACCEPT: begin
				in_ready   = sts.slot_free;
				cmd.accept = in_valid && sts.slot_free;
			end
			rlbd_pkg::ST_REPEAT: begin
				cmd.emit_rep = sts.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hdl/rlbd_dp.sv
`include "run_length_byte_decoder_top_macros.svh"

module rlbd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [5:0]         threshold,
	input  logic               req_type,
	input  logic [7:0]         data_byte,
	input  rlbd_pkg::ctl_cmd_t cmd,
	output rlbd_pkg::dp_sts_t  sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         out_byte,
	output logic [1:0]         result_status,
	output logic [7:0]         pending_count,
	output logic               last_of_run
);

	rlbd_pkg::mode_t mode_q;
	logic [7:0] rem_q;
	logic [7:0] rep_byte_q;
	logic [6:0] rep_cnt_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] status_q;
	logic [7:0] pending_q;
	logic       last_q;

	logic       run_active;
	logic       is_rep;
	logic       is_lit;
	logic       load_out;
	logic [6:0] rep_len;

	assign run_active = (rem_q != 8'd0) &&
		((mode_q == rlbd_pkg::MODE_REP) || (mode_q == rlbd_pkg::MODE_LIT));
	assign is_rep  = run_active && (mode_q == rlbd_pkg::MODE_REP);
	assign is_lit  = run_active && (mode_q == rlbd_pkg::MODE_LIT);
	assign rep_len = (rem_q > rlbd_pkg::REPEAT_MAX) ? rlbd_pkg::REPEAT_MAX[6:0] : rem_q[6:0];

	assign load_out = cmd.emit_rep ||
		(cmd.accept && ((req_type == rlbd_pkg::REQ_CHECK) || is_lit));

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.start_rep = (req_type == rlbd_pkg::REQ_DATA) && is_rep;
	assign sts.rep_last  = (rep_cnt_q == 7'd1);

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rlbd_pkg::MODE_DIR;
			rem_q     <= 8'd0;
			rep_cnt_q <= 7'd0;
		end else if (cmd.accept && (req_type == rlbd_pkg::REQ_DATA)) begin
			if (is_rep) begin
				mode_q    <= rlbd_pkg::MODE_DIR;
				rem_q     <= 8'd0;
				rep_cnt_q <= rep_len;
			end else if (is_lit) begin
				rem_q <= rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					mode_q <= rlbd_pkg::MODE_DIR;
				end
			end else if (data_byte <= {2'b00, threshold}) begin
				mode_q <= rlbd_pkg::MODE_REP;
				rem_q  <= data_byte + 8'd1;
			end else begin
				mode_q <= rlbd_pkg::MODE_LIT;
				rem_q  <= data_byte - {2'b00, threshold};
			end
		end else if (cmd.emit_rep) begin
			rep_cnt_q <= rep_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.start_rep) begin
			rep_byte_q <= data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rep) begin
			out_byte_q <= rep_byte_q;
			status_q   <= rlbd_pkg::STAT_BYTE;
			pending_q  <= 8'd0;
			last_q     <= sts.rep_last;
		end else if (load_out) begin
			last_q <= 1'b1;
			if (req_type == rlbd_pkg::REQ_CHECK) begin
				out_byte_q <= 8'd0;
				if (is_rep) begin
					status_q  <= rlbd_pkg::STAT_REP_OPEN;
					pending_q <= rem_q;
				end else if (is_lit) begin
					status_q  <= rlbd_pkg::STAT_LIT_OPEN;
					pending_q <= rem_q;
				end else begin
					status_q  <= rlbd_pkg::STAT_COMPLETE;
					pending_q <= 8'd0;
				end
			end else begin
				out_byte_q <= data_byte;
				status_q   <= rlbd_pkg::STAT_BYTE;
				pending_q  <= 8'd0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign result_status = status_q;
	assign pending_count = pending_q;
	assign last_of_run   = last_q;

	`RLBD_ASSERT_NOW(a_emit_has_count, clk, arst_n, cmd.emit_rep, rep_cnt_q != 7'd0)
	`RLBD_ASSERT_NOW(a_run_not_empty, clk, arst_n, mode_q != rlbd_pkg::MODE_DIR, rem_q != 8'd0)
	`RLBD_ASSERT_NEXT(a_repeat_start, clk, arst_n, cmd.accept && sts.start_rep,
		(mode_q == rlbd_pkg::MODE_DIR) && (rep_cnt_q != 7'd0))
	`RLBD_ASSERT_NOW(a_no_overlap, clk, arst_n, cmd.emit_rep, !cmd.accept)

endmodule

### hdl/run_length_byte_decoder_top.sv
// results: a check or literal byte is registered in the single output register, a
// directive gives none; data byte or check: one item per cycle while the output is free
// repeat run of n bytes: data byte taken, then the repeat counter emits the n bytes
// with input held off
// reset: run state cleared to waiting for directive, output empty, threshold 63
module run_length_byte_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte, pending_count
	output logic [1:0]  m_axis_tuser,  // result_status
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0]         threshold;
	rlbd_pkg::ctl_cmd_t cmd;
	rlbd_pkg::dp_sts_t  sts;

	rlbd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	rlbd_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rlbd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.threshold     (threshold),
		.req_type      (s_axis_tuser),
		.data_byte     (s_axis_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_byte      (m_axis_tdata[7:0]),
		.result_status (m_axis_tuser),
		.pending_count (m_axis_tdata[15:8]),
		.last_of_run   (m_axis_tlast)
	);

endmodule
